>>> src/touch_centroid_and_spread_defines.svh
// Assertion helpers for the checker file.
`ifndef TOUCH_CENTROID_AND_SPREAD_DEFINES_SVH
`define TOUCH_CENTROID_AND_SPREAD_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/tcs_pkg.sv
package tcs_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int OUT_W        = 16;
  localparam int CHANNELS_DEF = 26;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'd3276;

  // Chunk width of the shared multiplier; its y operand is split into two chunks
  localparam int MUL_CHUNK = 17;
  localparam int MUL_Y_W   = 2 * MUL_CHUNK;

  // Fraction bits of the spread quotient, quotient bits of the position
  localparam int FRAC_SHIFT = 26;
  localparam int POS_QB     = 16;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCUM,
    OP_CLR,
    OP_MUL_SQ,
    OP_MUL_WW,
    OP_MUL_SS,
    OP_MOVT,
    OP_SUBT,
    OP_PREP_SPR,
    OP_DIV,
    OP_PREP_SQRT,
    OP_SQRT,
    OP_SET_SPR,
    OP_PREP_POS,
    OP_SET_POS,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_FRAME,
    COND_SZERO,
    COND_EMIT,
    COND_JUMP
  } cond_t;

  typedef enum logic [2:0] {
    LOOP_ONE,
    LOOP_MUL,
    LOOP_DIVS,
    LOOP_DIVP,
    LOOP_SQRT
  } loop_t;

  typedef struct packed {
    op_t             op;
    loop_t           lsel;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic first;
  } dp_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic frame_done;
    logic s_zero;
    logic out_free;
  } dp_stat_t;

  localparam logic [PC_W-1:0] STEP_ACCUM     = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK     = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_SQ    = 4'd2;
  localparam logic [PC_W-1:0] STEP_MOVT      = 4'd3;
  localparam logic [PC_W-1:0] STEP_MUL_WW    = 4'd4;
  localparam logic [PC_W-1:0] STEP_SUBT      = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL_SS    = 4'd6;
  localparam logic [PC_W-1:0] STEP_PREP_SPR  = 4'd7;
  localparam logic [PC_W-1:0] STEP_DIV_SPR   = 4'd8;
  localparam logic [PC_W-1:0] STEP_PREP_SQRT = 4'd9;
  localparam logic [PC_W-1:0] STEP_SQRT      = 4'd10;
  localparam logic [PC_W-1:0] STEP_SET_SPR   = 4'd11;
  localparam logic [PC_W-1:0] STEP_PREP_POS  = 4'd12;
  localparam logic [PC_W-1:0] STEP_DIV_POS   = 4'd13;
  localparam logic [PC_W-1:0] STEP_SET_POS   = 4'd14;
  localparam logic [PC_W-1:0] STEP_EMIT      = 4'd15;

  // Frame program: accumulate; if S is nonzero, n = S*Q - W*W, spread = isqrt(n*2^26 / 25S^2),
  // position = W*2^15 / ((CHANNELS-1)*S), else both zero; then hand the result to the output register.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t uw;
    uw = '{op: OP_NOP, lsel: LOOP_ONE, cond: COND_JUMP, target: STEP_ACCUM};
    case (pc)
      STEP_ACCUM:     uw = '{OP_ACCUM,     LOOP_ONE,  COND_FRAME, STEP_ACCUM};
      STEP_CHECK:     uw = '{OP_CLR,       LOOP_ONE,  COND_SZERO, STEP_EMIT};
      STEP_MUL_SQ:    uw = '{OP_MUL_SQ,    LOOP_MUL,  COND_NEXT,  STEP_ACCUM};
      STEP_MOVT:      uw = '{OP_MOVT,      LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_MUL_WW:    uw = '{OP_MUL_WW,    LOOP_MUL,  COND_NEXT,  STEP_ACCUM};
      STEP_SUBT:      uw = '{OP_SUBT,      LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_MUL_SS:    uw = '{OP_MUL_SS,    LOOP_MUL,  COND_NEXT,  STEP_ACCUM};
      STEP_PREP_SPR:  uw = '{OP_PREP_SPR,  LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_DIV_SPR:   uw = '{OP_DIV,       LOOP_DIVS, COND_NEXT,  STEP_ACCUM};
      STEP_PREP_SQRT: uw = '{OP_PREP_SQRT, LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_SQRT:      uw = '{OP_SQRT,      LOOP_SQRT, COND_NEXT,  STEP_ACCUM};
      STEP_SET_SPR:   uw = '{OP_SET_SPR,   LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_PREP_POS:  uw = '{OP_PREP_POS,  LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_DIV_POS:   uw = '{OP_DIV,       LOOP_DIVP, COND_NEXT,  STEP_ACCUM};
      STEP_SET_POS:   uw = '{OP_SET_POS,   LOOP_ONE,  COND_NEXT,  STEP_ACCUM};
      STEP_EMIT:      uw = '{OP_EMIT,      LOOP_ONE,  COND_EMIT,  STEP_ACCUM};
      default:        uw = '{OP_NOP,       LOOP_ONE,  COND_JUMP,  STEP_ACCUM};
    endcase
    return uw;
  endfunction

endpackage

>>> src/touch_centroid_and_spread.sv
// Accepts one sample beat per cycle while a frame is being collected.
// After the last channel of a frame the shared datapath forms the products and runs the
// bit-serial divide and square root loops for the spread, then the position divide; when no
// channel counted it goes straight to the result beat. SQB, the spread quotient width, sets
// the spread loop lengths. Samples stall until the result beat enters the output register.
// Synchronous active-low reset clears the sums, channel index and output valid, and loads 3276.
module touch_centroid_and_spread #(
  parameter int CHANNELS = tcs_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcs_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_touched,
  output logic [tcs_pkg::OUT_W-1:0]    out_position,
  output logic [tcs_pkg::OUT_W-1:0]    out_spread,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcs_pkg::SAMPLE_W-1:0] cfg_detect_threshold
);
  import tcs_pkg::*;

  localparam longint unsigned RMAX = 64'd65535;
  localparam int CH_W  = $clog2(CHANNELS);
  localparam int I2_W  = $clog2((CHANNELS - 1) * (CHANNELS - 1) + 1);
  localparam int S_W   = $clog2(RMAX * CHANNELS + 1);
  localparam int W_W   = $clog2(RMAX * ((CHANNELS * (CHANNELS - 1)) / 2) + 1);
  localparam int Q_W   =
    $clog2(RMAX * (((CHANNELS - 1) * CHANNELS * (2 * CHANNELS - 1)) / 6) + 1);
  localparam int X_W   = (S_W > W_W) ? S_W : W_W;
  localparam int AW    = X_W + MUL_Y_W;
  localparam int NW    = S_W + Q_W;
  localparam int RW    = 2 * S_W + 5;
  // Spread quotient bound: variance <= (CHANNELS-1)^2/4, scaled by 2^26/25
  localparam longint unsigned QMAX =
    ((CHANNELS - 1) * (CHANNELS - 1) * (64'd1 << (FRAC_SHIFT - 2))) / 25;
  localparam int SQ_RAW = $clog2(QMAX + 1);
  localparam int SQ_MIN = (SQ_RAW > FRAC_SHIFT + 2) ? SQ_RAW : FRAC_SHIFT + 2;
  localparam int SQB    = ((SQ_MIN + 1) / 2) * 2;
  localparam int RTB    = SQB / 2;
  localparam int CW     = $clog2(SQB + 1);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  tcs_sequencer #(
    .SQB (SQB),
    .RTB (RTB),
    .CW  (CW)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  tcs_datapath #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W),
    .I2_W     (I2_W),
    .S_W      (S_W),
    .W_W      (W_W),
    .Q_W      (Q_W),
    .X_W      (X_W),
    .AW       (AW),
    .NW       (NW),
    .RW       (RW),
    .SQB      (SQB),
    .RTB      (RTB)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .stat                 (stat),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_touched          (out_touched),
    .out_position         (out_position),
    .out_spread           (out_spread),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_detect_threshold (cfg_detect_threshold)
  );

endmodule

>>> src/tcs_sequencer.sv
module tcs_sequencer #(
  parameter int SQB = 30,
  parameter int RTB = 15,
  parameter int CW  = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcs_pkg::dp_stat_t  stat,
  output tcs_pkg::dp_ctl_t   ctl
);
  import tcs_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   cnt_last;
  logic            step_done;
  uword_t          uw;

  // Fetch the control word of the current step
  assign uw = ucode_rom(pc_r);

  // Loop length of the step
  always_comb begin
    case (uw.lsel)
      LOOP_ONE:  cnt_last = '0;
      LOOP_MUL:  cnt_last = CW'(1);
      LOOP_DIVS: cnt_last = CW'(SQB - 1);
      LOOP_DIVP: cnt_last = CW'(POS_QB - 1);
      LOOP_SQRT: cnt_last = CW'(RTB - 1);
      default:   cnt_last = '0;
    endcase
  end

  assign step_done = (cnt_r == cnt_last);

  // Advance the step counter, take jumps
  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = '0;
    if (!step_done) begin
      cnt_nxt = cnt_r + CW'(1);
    end else begin
      case (uw.cond)
        COND_NEXT:  pc_nxt = pc_r + PC_W'(1);
        COND_FRAME: pc_nxt = stat.frame_done ? pc_r + PC_W'(1) : pc_r;
        COND_SZERO: pc_nxt = stat.s_zero ? uw.target : pc_r + PC_W'(1);
        COND_EMIT:  pc_nxt = stat.out_free ? uw.target : pc_r;
        COND_JUMP:  pc_nxt = uw.target;
        default:    pc_nxt = uw.target;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= STEP_ACCUM;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign ctl.op    = uw.op;
  assign ctl.first = (cnt_r == '0);

endmodule

>>> src/tcs_datapath.sv
module tcs_datapath #(
  parameter int CHANNELS = 26,
  parameter int CH_W     = 5,
  parameter int I2_W     = 10,
  parameter int S_W      = 21,
  parameter int W_W      = 25,
  parameter int Q_W      = 29,
  parameter int X_W      = 25,
  parameter int AW       = 59,
  parameter int NW       = 50,
  parameter int RW       = 47,
  parameter int SQB      = 30,
  parameter int RTB      = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcs_pkg::dp_ctl_t                  ctl,
  output tcs_pkg::dp_stat_t                 stat,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tcs_pkg::SAMPLE_W-1:0]      in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_touched,
  output logic [tcs_pkg::OUT_W-1:0]         out_position,
  output logic [tcs_pkg::OUT_W-1:0]         out_spread,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcs_pkg::SAMPLE_W-1:0]      cfg_detect_threshold
);
  import tcs_pkg::*;

  localparam int PW  = X_W + MUL_CHUNK;
  localparam int SRW = RTB + 3;
  localparam int LW  = SQB;

  // Control state
  logic [SAMPLE_W-1:0] thr_r, thr_nxt;
  logic [CH_W-1:0]     chan_r, chan_nxt;
  logic [I2_W-1:0]     i2_r, i2_nxt;
  logic [S_W-1:0]      s_r, s_nxt;
  logic [W_W-1:0]      w_r, w_nxt;
  logic [Q_W-1:0]      q_r, q_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Working registers
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [NW-1:0]       t_r, t_nxt;
  logic [RW-1:0]       dvs_r, dvs_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [LW-1:0]       low_r, low_nxt;
  logic [SQB-1:0]      quo_r, quo_nxt;
  logic [SRW-1:0]      srem_r, srem_nxt;
  logic [RTB-1:0]      root_r, root_nxt;
  logic [OUT_W-1:0]    pos_r, pos_nxt;
  logic [OUT_W-1:0]    spr_r, spr_nxt;
  logic                touched_r, touched_nxt;
  logic [OUT_W-1:0]    out_pos_r, out_pos_nxt;
  logic [OUT_W-1:0]    out_spr_r, out_spr_nxt;

  logic                in_fire, out_fire, last_chan, out_free;
  logic [W_W-1:0]      prod_w;
  logic [Q_W-1:0]      prod_q;
  logic [X_W-1:0]      mx;
  logic [MUL_Y_W-1:0]  my;
  logic [MUL_CHUNK-1:0] mchunk;
  logic [PW-1:0]       prod;
  logic [RW:0]         dtrial;
  logic [SRW-1:0]      sshift, ssub;
  logic                sge;

  // Handshakes
  assign in_stall  = (ctl.op != OP_ACCUM);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_chan = (chan_r == CH_W'(CHANNELS - 1));
  assign cfg_ready = 1'b1;

  assign stat.frame_done = in_fire && last_chan;
  assign stat.s_zero     = (s_r == '0);
  assign stat.out_free   = out_free;

  // Per-sample weights
  assign prod_w = W_W'(chan_r) * W_W'(in_sample);
  assign prod_q = Q_W'(i2_r) * Q_W'(in_sample);

  // Multiplier operand select, one 17-bit chunk of y per cycle
  always_comb begin
    case (ctl.op)
      OP_MUL_SQ: begin
        mx = X_W'(s_r);
        my = MUL_Y_W'(q_r);
      end
      OP_MUL_WW: begin
        mx = X_W'(w_r);
        my = MUL_Y_W'(w_r);
      end
      default: begin
        mx = X_W'(s_r);
        my = MUL_Y_W'(s_r);
      end
    endcase
  end

  assign mchunk = ctl.first ? my[MUL_CHUNK-1:0] : my[MUL_Y_W-1:MUL_CHUNK];
  assign prod   = PW'(mx) * PW'(mchunk);

  // Restoring divide step
  assign dtrial = {rem_r, low_r[LW-1]} - {1'b0, dvs_r};

  // Square root digit step
  assign sshift = {srem_r[SRW-3:0], low_r[LW-1:LW-2]};
  assign ssub   = SRW'({root_r, 2'b01});
  assign sge    = (sshift >= ssub);

  // Next values for the current step
  always_comb begin
    thr_nxt       = thr_r;
    chan_nxt      = chan_r;
    i2_nxt        = i2_r;
    s_nxt         = s_r;
    w_nxt         = w_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quo_nxt       = quo_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    pos_nxt       = pos_r;
    spr_nxt       = spr_r;
    touched_nxt   = touched_r;
    out_pos_nxt   = out_pos_r;
    out_spr_nxt   = out_spr_r;

    if (cfg_valid) begin
      thr_nxt = cfg_detect_threshold;
    end
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (ctl.op)
      OP_ACCUM: begin
        if (in_fire) begin
          if (in_sample > thr_r) begin
            s_nxt = s_r + S_W'(in_sample);
            w_nxt = w_r + prod_w;
            q_nxt = q_r + prod_q;
          end
          if (last_chan) begin
            chan_nxt = '0;
            i2_nxt   = '0;
          end else begin
            chan_nxt = chan_r + CH_W'(1);
            i2_nxt   = i2_r + I2_W'({chan_r, 1'b1});
          end
        end
      end
      OP_CLR: begin
        pos_nxt = '0;
        spr_nxt = '0;
      end
      OP_MUL_SQ, OP_MUL_WW, OP_MUL_SS: begin
        acc_nxt = ctl.first ? AW'(prod) : acc_r + (AW'(prod) << MUL_CHUNK);
      end
      OP_MOVT: begin
        t_nxt = NW'(acc_r);
      end
      OP_SUBT: begin
        t_nxt = t_r - NW'(acc_r);
      end
      OP_PREP_SPR: begin
        // 25*S^2; the remainder starts with the bits above the quotient range
        dvs_nxt = (RW'(acc_r) << 4) + (RW'(acc_r) << 3) + RW'(acc_r);
        rem_nxt = RW'(t_r >> (SQB - FRAC_SHIFT));
        low_nxt = {t_r[SQB-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
        quo_nxt = '0;
      end
      OP_DIV: begin
        if (!dtrial[RW]) begin
          rem_nxt = dtrial[RW-1:0];
        end else begin
          rem_nxt = {rem_r[RW-2:0], low_r[LW-1]};
        end
        low_nxt = {low_r[LW-2:0], 1'b0};
        quo_nxt = {quo_r[SQB-2:0], !dtrial[RW]};
      end
      OP_PREP_SQRT: begin
        low_nxt  = LW'(quo_r);
        srem_nxt = '0;
        root_nxt = '0;
      end
      OP_SQRT: begin
        srem_nxt = sge ? sshift - ssub : sshift;
        root_nxt = {root_r[RTB-2:0], sge};
        low_nxt  = {low_r[LW-3:0], 2'b00};
      end
      OP_SET_SPR: begin
        spr_nxt = OUT_W'(root_r);
      end
      OP_PREP_POS: begin
        // W*2^15 / ((CHANNELS-1)*S), quotient fits in 16 bits
        dvs_nxt = RW'(s_r) * RW'(CHANNELS - 1);
        rem_nxt = RW'(w_r >> 1);
        low_nxt = {w_r[0], {(LW - 1){1'b0}}};
        quo_nxt = '0;
      end
      OP_SET_POS: begin
        pos_nxt = OUT_W'(quo_r);
      end
      OP_EMIT: begin
        if (out_free) begin
          touched_nxt   = (s_r != '0);
          out_pos_nxt   = pos_r;
          out_spr_nxt   = spr_r;
          out_valid_nxt = 1'b1;
          s_nxt         = '0;
          w_nxt         = '0;
          q_nxt         = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESH_RESET;
      chan_r      <= '0;
      i2_r        <= '0;
      s_r         <= '0;
      w_r         <= '0;
      q_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      chan_r      <= chan_nxt;
      i2_r        <= i2_nxt;
      s_r         <= s_nxt;
      w_r         <= w_nxt;
      q_r         <= q_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    dvs_r     <= dvs_nxt;
    rem_r     <= rem_nxt;
    low_r     <= low_nxt;
    quo_r     <= quo_nxt;
    srem_r    <= srem_nxt;
    root_r    <= root_nxt;
    pos_r     <= pos_nxt;
    spr_r     <= spr_nxt;
    touched_r <= touched_nxt;
    out_pos_r <= out_pos_nxt;
    out_spr_r <= out_spr_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_touched  = touched_r;
  assign out_position = out_pos_r;
  assign out_spread   = out_spr_r;

endmodule

>>> src/tcs_checker.sv
`include "touch_centroid_and_spread_defines.svh"

module tcs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_touched,
  input logic [tcs_pkg::OUT_W-1:0]    out_position,
  input logic [tcs_pkg::OUT_W-1:0]    out_spread
);
  import tcs_pkg::*;

  // Hold a stalled result beat
  `TCS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")
  `TCS_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_touched) && $stable(out_position) && $stable(out_spread), "stalled result beat changed")

  // An untouched frame reports zero position and spread
  `TCS_ASSERT(a_untouched_zero, clk, rst_n, out_valid && !out_touched |-> out_position == '0 && out_spread == '0, "untouched frame with nonzero result")

  // Position never passes the end of the bar
  `TCS_ASSERT(a_pos_range, clk, rst_n, out_valid |-> out_position <= OUT_W'(32768), "position above full scale")

  // Reset drops any pending result
  `TCS_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind touch_centroid_and_spread tcs_checker u_tcs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_touched  (out_touched),
  .out_position (out_position),
  .out_spread   (out_spread)
);
